FILE: design/frame_periodic_task_scheduler_macros.svh
// assertion macros shared by the checker of the frame periodic task scheduler
// depends on nothing; taken in by `include
`ifndef FRAME_PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define FRAME_PERIODIC_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define FPTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define FPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fpts_pkg.sv
// shared codes and field widths of the frame periodic task scheduler
// depends on nothing
`default_nettype none
package fpts_pkg;

    localparam int FIELD_W = 32;
    localparam int SLOT_W  = 4;
    localparam int PRIO_W  = 8;
    localparam int ACT_W   = 3;
    localparam int KIND_W  = 2;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [KIND_W-1:0] kind_t;

    // actions
    localparam action_t ACT_INS_ABS  = 3'd0;
    localparam action_t ACT_INS_NEXT = 3'd1;
    localparam action_t ACT_TICK     = 3'd2;
    localparam action_t ACT_KILL     = 3'd3;
    localparam action_t ACT_SET_PER  = 3'd4;
    localparam action_t ACT_KILL_ALL = 3'd5;
    localparam action_t ACT_SET_CNT  = 3'd6;

    // result kinds
    localparam kind_t KIND_INS  = 2'd0;
    localparam kind_t KIND_RUN  = 2'd1;
    localparam kind_t KIND_ACK  = 2'd2;
    localparam kind_t KIND_FULL = 2'd3;

endpackage
`default_nettype wire

FILE: design/fpts_ram.sv
// generic simple dual port ram, one write port, one registered read port
// depends on nothing
`default_nettype none
module fpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/frame_periodic_task_scheduler.sv
// frame periodic task scheduler: insert, kill, set period and tick a table of periodic tasks
// also kill all and set the frame counter; single commands answer via S_RESULT, kill or set
// period of a valid slot via S_RMW; kill all sweeps each slot; a tick scans the ram per pick
// one item at a time; the single read port of the task ram sets the scan length
// reset (rst_n low, async) clears valid bits, frame counter and insertion stamp
// task ram contents are not cleared; entries are used only while valid
`default_nettype none
module frame_periodic_task_scheduler
    import fpts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // start_frame, end_frame, period, priority_req, task_tag, slot, zero pad
    input  wire logic [143:0] s_axis_tdata,
    // action
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // run_tag, run_slot, frame, idle, zero pad
    output logic [71:0]       m_axis_tdata,
    // kind
    output logic [1:0]        m_axis_tuser,
    // last
    output logic              m_axis_tlast
);

    localparam int IW    = $clog2(MAX_TASKS);
    localparam int CW    = IW + 1;
    localparam int REC_W = 5 * FIELD_W + PRIO_BITS;

    typedef logic [IW-1:0]        idx_t;
    typedef logic [CW-1:0]        cnt_t;
    typedef logic [PRIO_BITS-1:0] prio_t;
    typedef logic [MAX_TASKS-1:0] mask_t;

    typedef struct packed {
        logic [FIELD_W-1:0] next_f;
        logic [FIELD_W-1:0] end_f;
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] tag;
        logic [FIELD_W-1:0] stamp;
        prio_t              prio;
    } rec_t;

    localparam cnt_t CNT_FULL = cnt_t'(MAX_TASKS);
    localparam cnt_t CNT_LAST = cnt_t'(MAX_TASKS - 1);

    // states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESULT  = 4'd1;
    localparam logic [3:0] S_RMW     = 4'd2;
    localparam logic [3:0] S_KALL_RD = 4'd3;
    localparam logic [3:0] S_KALL_WR = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_PICK    = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    logic [3:0]          state_reg, state_next;
    mask_t               valid_reg, valid_next;
    mask_t               done_reg, done_next;
    mask_t               expire_reg, expire_next;
    logic [FIELD_W-1:0]  fc_reg, fc_next;
    logic [FIELD_W-1:0]  stamp_reg, stamp_next;
    cnt_t                cnt_reg, cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    idx_t                chk_idx_reg, chk_idx_next;
    logic                have_best_reg, have_best_next;
    idx_t                best_idx_reg, best_idx_next;
    logic [FIELD_W-1:0]  best_age_reg, best_age_next;
    prio_t               best_prio_reg, best_prio_next;
    rec_t                best_rec_reg, best_rec_next;
    idx_t                op_idx_reg, op_idx_next;
    logic [FIELD_W-1:0]  op_val_reg, op_val_next;
    logic                op_kill_reg, op_kill_next;
    kind_t               res_kind_reg, res_kind_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [FIELD_W-1:0]  res_frame_reg, res_frame_next;
    logic                ov_reg, ov_next;
    kind_t               okind_reg, okind_next;
    logic [FIELD_W-1:0]  otag_reg, otag_next;
    logic [SLOT_W-1:0]   oslot_reg, oslot_next;
    logic [FIELD_W-1:0]  oframe_reg, oframe_next;
    logic                oidle_reg, oidle_next;
    logic                olast_reg, olast_next;

    // ram ports
    logic                ram_we;
    idx_t                ram_waddr, ram_raddr;
    rec_t                ram_wrec, rd_rec;
    logic [REC_W-1:0]    ram_rdata;

    // input fields
    action_t             in_action;
    logic [FIELD_W-1:0]  in_start, in_end, in_period, in_tag;
    logic [PRIO_W-1:0]   in_prio;
    logic [SLOT_W-1:0]   in_slot;
    logic [15:0]         in_prio_wide;
    idx_t                in_idx;
    logic                slot_ok, in_acc, out_free;

    // free slot search and scan checks
    logic                free_found;
    idx_t                free_idx;
    logic [FIELD_W-1:0]  chk_age;
    logic                chk_elig, chk_beat, chk_exp;

    assign in_action    = s_axis_tuser;
    assign in_start     = s_axis_tdata[31:0];
    assign in_end       = s_axis_tdata[63:32];
    assign in_period    = s_axis_tdata[95:64];
    assign in_prio      = s_axis_tdata[103:96];
    assign in_tag       = s_axis_tdata[135:104];
    assign in_slot      = s_axis_tdata[139:136];
    assign in_prio_wide = {8'd0, in_prio};
    assign in_idx       = idx_t'(in_slot);
    assign slot_ok      = ({28'd0, in_slot} < 32'(MAX_TASKS));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {3'd0, oidle_reg, oframe_reg, oslot_reg, otag_reg};
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = idx_t'(i);
            end
        end
    end

    // checks on the entry read back during a scan
    assign rd_rec   = rec_t'(ram_rdata);
    assign chk_age  = stamp_reg - rd_rec.stamp;
    assign chk_elig = valid_reg[chk_idx_reg] && !done_reg[chk_idx_reg]
                      && (rd_rec.next_f == fc_reg) && !(rd_rec.end_f < fc_reg);
    assign chk_beat = !have_best_reg || (rd_rec.prio > best_prio_reg)
                      || ((rd_rec.prio == best_prio_reg) && (chk_age > best_age_reg));
    assign chk_exp  = valid_reg[chk_idx_reg] && (fc_reg != '1)
                      && (rd_rec.end_f <= fc_reg);

    // control and datapath
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        done_next      = done_reg;
        expire_next    = expire_reg;
        fc_next        = fc_reg;
        stamp_next     = stamp_reg;
        cnt_next       = cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        best_prio_next = best_prio_reg;
        best_rec_next  = best_rec_reg;
        op_idx_next    = op_idx_reg;
        op_val_next    = op_val_reg;
        op_kill_next   = op_kill_reg;
        res_kind_next  = res_kind_reg;
        res_slot_next  = res_slot_reg;
        res_frame_next = res_frame_reg;
        ov_next        = ov_reg && !m_axis_tready;
        okind_next     = okind_reg;
        otag_next      = otag_reg;
        oslot_next     = oslot_reg;
        oframe_next    = oframe_reg;
        oidle_next     = oidle_reg;
        olast_next     = olast_reg;
        ram_we         = 1'b0;
        ram_waddr      = op_idx_reg;
        ram_wrec       = rd_rec;
        ram_raddr      = in_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_kind_next  = KIND_ACK;
                    res_slot_next  = '0;
                    res_frame_next = fc_reg;
                    state_next     = S_RESULT;
                    unique case (in_action) inside
                        ACT_INS_ABS, ACT_INS_NEXT:
                        begin
                            if (free_found)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = free_idx;
                                ram_wrec.next_f = (in_action == ACT_INS_ABS) ?
                                                  in_start : fc_reg + 32'd1;
                                ram_wrec.end_f  = in_end;
                                ram_wrec.period = in_period;
                                ram_wrec.tag    = in_tag;
                                ram_wrec.stamp  = stamp_reg;
                                ram_wrec.prio   = in_prio_wide[PRIO_BITS-1:0];
                                valid_next[free_idx] = 1'b1;
                                stamp_next      = stamp_reg + 32'd1;
                                res_kind_next   = KIND_INS;
                                res_slot_next   = SLOT_W'(free_idx);
                            end
                            else
                            begin
                                res_kind_next = KIND_FULL;
                            end
                        end
                        ACT_TICK:
                        begin
                            done_next      = '0;
                            expire_next    = '0;
                            have_best_next = 1'b0;
                            cnt_next       = '0;
                            state_next     = S_SCAN;
                        end
                        ACT_KILL, ACT_SET_PER:
                        begin
                            op_idx_next  = in_idx;
                            op_val_next  = in_period;
                            op_kill_next = (in_action == ACT_KILL);
                            if (slot_ok && valid_reg[in_idx])
                            begin
                                state_next = S_RMW;
                            end
                        end
                        ACT_KILL_ALL:
                        begin
                            cnt_next   = '0;
                            state_next = S_KALL_RD;
                        end
                        ACT_SET_CNT:
                        begin
                            fc_next        = in_start;
                            res_frame_next = in_start;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // single result of a non-tick action
            S_RESULT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = res_kind_reg;
                    otag_next   = '0;
                    oslot_next  = res_slot_reg;
                    oframe_next = res_frame_reg;
                    oidle_next  = ~|valid_reg;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // read data of the addressed slot is here: modify and write back
            S_RMW:
            begin
                ram_we    = 1'b1;
                ram_waddr = op_idx_reg;
                if (op_kill_reg)
                begin
                    ram_wrec.end_f = fc_reg;
                end
                else
                begin
                    ram_wrec.period = op_val_reg;
                end
                state_next = S_RESULT;
            end

            // kill all sweep, read phase
            S_KALL_RD:
            begin
                ram_raddr  = cnt_reg[IW-1:0];
                state_next = S_KALL_WR;
            end

            // kill all sweep, write phase
            S_KALL_WR:
            begin
                ram_we         = valid_reg[cnt_reg[IW-1:0]];
                ram_waddr      = cnt_reg[IW-1:0];
                ram_wrec.end_f = fc_reg;
                cnt_next       = cnt_reg + cnt_t'(1);
                state_next     = (cnt_reg == CNT_LAST) ? S_RESULT : S_KALL_RD;
            end

            // one pass over the ram for the best due task
            S_SCAN:
            begin
                ram_raddr = cnt_reg[IW-1:0];
                if (cnt_reg != CNT_FULL)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[IW-1:0];
                    cnt_next     = cnt_reg + cnt_t'(1);
                end
                if (chk_vld_reg)
                begin
                    expire_next[chk_idx_reg] = chk_exp;
                    if (chk_elig && chk_beat)
                    begin
                        have_best_next = 1'b1;
                        best_idx_next  = chk_idx_reg;
                        best_age_next  = chk_age;
                        best_prio_next = rd_rec.prio;
                        best_rec_next  = rd_rec;
                    end
                end
                else if (cnt_reg == CNT_FULL)
                begin
                    state_next = have_best_reg ? S_PICK : S_DONE;
                end
            end

            // emit the picked task and advance its next frame
            S_PICK:
            begin
                if (out_free)
                begin
                    ov_next         = 1'b1;
                    okind_next      = KIND_RUN;
                    otag_next       = best_rec_reg.tag;
                    oslot_next      = SLOT_W'(best_idx_reg);
                    oframe_next     = fc_reg;
                    oidle_next      = ~|(valid_reg & ~expire_reg);
                    olast_next      = 1'b0;
                    ram_we          = 1'b1;
                    ram_waddr       = best_idx_reg;
                    ram_wrec        = best_rec_reg;
                    ram_wrec.next_f = fc_reg + best_rec_reg.period;
                    done_next[best_idx_reg] = 1'b1;
                    have_best_next  = 1'b0;
                    cnt_next        = '0;
                    state_next      = S_SCAN;
                end
            end

            // frame done: drop expired tasks, advance the counter
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_ACK;
                    otag_next   = '0;
                    oslot_next  = '0;
                    oframe_next = fc_reg;
                    oidle_next  = ~|(valid_reg & ~expire_reg);
                    olast_next  = 1'b1;
                    valid_next  = valid_reg & ~expire_reg;
                    fc_next     = fc_reg + 32'd1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            fc_reg        <= '0;
            stamp_reg     <= '0;
            ov_reg        <= 1'b0;
            chk_vld_reg   <= 1'b0;
            have_best_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            fc_reg        <= fc_next;
            stamp_reg     <= stamp_next;
            ov_reg        <= ov_next;
            chk_vld_reg   <= chk_vld_next;
            have_best_reg <= have_best_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        done_reg      <= done_next;
        expire_reg    <= expire_next;
        cnt_reg       <= cnt_next;
        chk_idx_reg   <= chk_idx_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        best_prio_reg <= best_prio_next;
        best_rec_reg  <= best_rec_next;
        op_idx_reg    <= op_idx_next;
        op_val_reg    <= op_val_next;
        op_kill_reg   <= op_kill_next;
        res_kind_reg  <= res_kind_next;
        res_slot_reg  <= res_slot_next;
        res_frame_reg <= res_frame_next;
        okind_reg     <= okind_next;
        otag_reg      <= otag_next;
        oslot_reg     <= oslot_next;
        oframe_reg    <= oframe_next;
        oidle_reg     <= oidle_next;
        olast_reg     <= olast_next;
    end

    // task table
    fpts_ram #(
        .WIDTH(REC_W),
        .DEPTH(MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrec),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

FILE: design/fpts_checker.sv
// port-level checks of the frame periodic task scheduler, bound to the top level
// depends on fpts_pkg and frame_periodic_task_scheduler_macros.svh
`default_nettype none
`include "frame_periodic_task_scheduler_macros.svh"
module fpts_checker
    import fpts_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result beat stays offered
    `FPTS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

    // one item at a time: no input beat right after one was taken
    `FPTS_ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

    // a run beat is never the closing beat of a tick
    `FPTS_ASSERT_NOW(a_run_not_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_RUN), !m_axis_tlast, "run beat marked last")

    // insert answers are single beats
    `FPTS_ASSERT_NOW(a_ins_last, clk, rst_n, m_axis_tvalid && ((m_axis_tuser == KIND_INS) || (m_axis_tuser == KIND_FULL)), m_axis_tlast, "insert answer not last")

endmodule

bind frame_periodic_task_scheduler fpts_checker u_fpts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
